FILE: src/frm_pkg.sv
// Shared types, constants and helpers of the fuzzy run matcher.
package frm_pkg;

  localparam int TERM_MAX   = 64;
  localparam int RUN_MAX    = 8;
  localparam int SOURCE_MAX = 4094;

  localparam int TERM_AW = $clog2(TERM_MAX);
  localparam int TP_W    = $clog2(TERM_MAX + 1);
  localparam int RL_W    = $clog2(RUN_MAX + 1);
  localparam int RB_AW   = $clog2(RUN_MAX);
  localparam int QN_W    = $clog2(RUN_MAX + 2);
  localparam int QDEPTH  = RUN_MAX + 1;

  localparam int SP_W  = 12;
  localparam int FC_W  = 6;
  localparam logic [FC_W-1:0] FRAG_SAT  = FC_W'(62);
  localparam logic [SP_W-1:0] COUNT_SAT = SP_W'(4094);

  localparam logic CMD_TERM   = 1'b0;
  localparam logic CMD_SOURCE = 1'b1;

  localparam logic REG_MIN_RUN  = 1'b0;
  localparam logic REG_TERM_LEN = 1'b1;

  typedef struct packed {
    logic [7:0] symbol;
    logic       hl;
    logic       fs;
  } frm_emit_t;

  typedef struct packed {
    logic [SP_W-1:0] mismatch_count;
    logic [SP_W-1:0] first_position;
    logic [FC_W-1:0] fragment_count;
    logic            matched;
    logic            fragment_start;
    logic            highlighted;
    logic [7:0]      out_symbol;
  } frm_result_t;

  // ASCII case folding: upper case letters map to lower case.
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: src/frm_ram.sv
// Generic single-port-write, registered-read RAM.
module frm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/fuzzy_run_matcher_core.sv
// Top level of the fuzzy run matcher: sequencer, run buffer, output staging.
//
// Term bytes (tuser 0) are written straight to the term RAM. A
// source byte (tuser 1) is worked through by a small sequencer that uses the
// single term RAM read port and one fold-and-compare unit: each compare is a
// RAM read, then a compare, and a broken short run replays its buffered
// bytes through the same compare, where they can break again. The block is
// not ready while a byte is in work, and an output stall holds the work up.
// Results go through a one-entry hold stage and an output register so that
// the last result of a string can carry the summary fields.
module fuzzy_run_matcher_core (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] symbol, [13:8] term_slot, [15:14] zero
  input  logic        s_tuser,   // cmd
  input  logic        s_tlast,   // final_byte
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] out_symbol, [8] highlighted,
                                 // [9] fragment_start, [10] matched,
                                 // [16:11] fragment_count, [28:17] first_position,
                                 // [40:29] mismatch_count, [47:41] zero
  output logic        m_tlast,   // end_of_string
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import frm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_ENDT  = 7'b0001000,
    S_FLUSH = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_DRAIN = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    FK_CONF  = 2'd0,
    FK_ENDT  = 2'd1,
    FK_FINAL = 2'd2
  } flush_kind_t;

  state_t      state;
  flush_kind_t flush_kind;

  logic [3:0] min_run;
  logic [6:0] term_length;

  logic [7:0]      pending [RUN_MAX];
  logic [7:0]      q [QDEPTH];
  logic [QN_W-1:0] qn;
  logic [RL_W-1:0] rl;
  logic [RL_W-1:0] fi;
  logic            flush_hl;
  logic            fin;
  logic [TP_W-1:0] tp;
  logic [TP_W-1:0] resume;
  logic [SP_W-1:0] srcpos;
  logic [FC_W-1:0] frags;
  logic [SP_W-1:0] first_at;
  logic [SP_W-1:0] mism;
  logic            done;
  logic            matched;
  logic [RL_W:0]   res_n;

  frm_emit_t   hold;
  logic        hold_v;
  frm_result_t out_reg;
  logic        out_v;
  logic        out_last;

  logic [RL_W-1:0] m_eff;
  logic [TP_W-1:0] len_eff;
  logic [7:0]      rdata;
  logic            ram_we;

  logic      em_req;
  frm_emit_t em;
  logic      em_go;
  logic      em_keep;
  logic      move_ok;
  logic      hit;

  logic [7:0]      nq [QDEPTH];
  logic [QN_W-1:0] nq_n;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = out_v;
  assign m_tlast   = out_last;
  assign m_tdata   = {7'd0, out_reg};

  // Clamped register values.
  always_comb begin
    if (min_run == 4'd0) begin
      m_eff = RL_W'(1);
    end else if (32'(min_run) > RUN_MAX) begin
      m_eff = RL_W'(RUN_MAX);
    end else begin
      m_eff = RL_W'(min_run);
    end
    if (term_length == 7'd0) begin
      len_eff = TP_W'(1);
    end else if (32'(term_length) > TERM_MAX) begin
      len_eff = TP_W'(TERM_MAX);
    end else begin
      len_eff = TP_W'(term_length);
    end
  end

  assign ram_we = s_tvalid && s_tready && (s_tuser == CMD_TERM) &&
                  (32'(s_tdata[13:8]) < TERM_MAX);

  frm_ram #(.WIDTH(8), .DEPTH(TERM_MAX)) u_term_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (TERM_AW'(s_tdata[13:8])),
    .wdata (s_tdata[7:0]),
    .raddr (tp[TERM_AW-1:0]),
    .rdata (rdata)
  );

  assign hit = (fold(rdata) == fold(q[0]));

  // Replay queue after a broken run: buffered bytes after the first, then
  // the breaking byte and whatever was still queued.
  always_comb begin
    int k;
    for (int j = 0; j < QDEPTH; j++) begin
      nq[j] = 8'd0;
      k = j - (int'(rl) - 1);
      if (j + 1 < int'(rl) && j + 1 < RUN_MAX) begin
        nq[j] = pending[RB_AW'(j + 1)];
      end else begin
        if (k >= 0 && k < QDEPTH) begin
          nq[j] = q[QN_W'(k)];
        end
      end
    end
    if (int'(rl) - 1 + int'(qn) > QDEPTH) begin
      nq_n = QN_W'(QDEPTH);
    end else begin
      nq_n = QN_W'(int'(rl) - 1 + int'(qn));
    end
  end

  // Emit request of the current sequencer step.
  always_comb begin
    em_req = 1'b0;
    em     = '{symbol: q[0], hl: 1'b0, fs: 1'b0};
    case (state)
      S_CHECK: begin
        if (!(!done && tp >= len_eff) && qn != '0 && done) begin
          em_req = 1'b1;
        end
      end
      S_CMP: begin
        if (hit && rl >= m_eff) begin
          em_req = 1'b1;
          em.hl  = 1'b1;
        end else if (!hit && rl != '0 && rl < m_eff) begin
          em_req    = 1'b1;
          em.symbol = pending[0];
        end else if (!hit) begin
          em_req = 1'b1;
        end
      end
      S_FLUSH: begin
        if (fi < rl) begin
          em_req    = 1'b1;
          em.symbol = pending[fi[RB_AW-1:0]];
          em.hl     = flush_hl;
          em.fs     = flush_hl && (fi == '0);
        end
      end
      default: begin
        em_req = 1'b0;
      end
    endcase
  end

  assign move_ok = !out_v || m_tready;
  assign em_keep = (32'(res_n) < RUN_MAX);
  assign em_go   = em_req && (!em_keep || !hold_v || move_ok);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      flush_kind <= FK_CONF;
      min_run    <= 4'd2;
      term_length <= 7'd1;
      qn         <= '0;
      rl         <= '0;
      fi         <= '0;
      flush_hl   <= 1'b0;
      fin        <= 1'b0;
      tp         <= '0;
      resume     <= '0;
      srcpos     <= '0;
      frags      <= '0;
      first_at   <= '1;
      mism       <= '0;
      done       <= 1'b0;
      matched    <= 1'b0;
      res_n      <= '0;
      hold_v     <= 1'b0;
      out_v      <= 1'b0;
      out_last   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MIN_RUN) begin
          min_run <= cfg_data[3:0];
        end else begin
          term_length <= cfg_data;
        end
      end

      if (out_v && m_tready) begin
        out_v <= 1'b0;
      end

      // Result staging shared by every emitting step.
      if (em_go && em_keep) begin
        res_n <= res_n + 1'b1;
        if (32'(srcpos) < SOURCE_MAX) begin
          srcpos <= srcpos + 1'b1;
        end
        if (hold_v) begin
          out_reg  <= '{out_symbol: hold.symbol, highlighted: hold.hl,
                        fragment_start: hold.fs, default: '0};
          out_last <= 1'b0;
          out_v    <= 1'b1;
        end
        hold   <= em;
        hold_v <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tuser == CMD_SOURCE) begin
            if (rl > m_eff) begin
              rl <= m_eff;
            end
            q[0]  <= s_tdata[7:0];
            qn    <= QN_W'(1);
            res_n <= '0;
            fin   <= s_tlast;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!done && tp >= len_eff) begin
            state <= S_ENDT;
          end else if (qn == '0) begin
            state <= S_FIN;
          end else if (done) begin
            if (em_go) begin
              if (matched && mism < COUNT_SAT) begin
                mism <= mism + 1'b1;
              end
              for (int j = 0; j < QDEPTH - 1; j++) begin
                q[j] <= q[j + 1];
              end
              qn <= qn - 1'b1;
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit && rl < m_eff) begin
            pending[rl[RB_AW-1:0]] <= q[0];
            rl <= rl + 1'b1;
            tp <= tp + 1'b1;
            for (int j = 0; j < QDEPTH - 1; j++) begin
              q[j] <= q[j + 1];
            end
            qn <= qn - 1'b1;
            if (rl + 1'b1 == m_eff) begin
              resume <= tp + 1'b1;
              if (frags == '0) begin
                first_at <= srcpos;
              end
              if (frags < FRAG_SAT) begin
                frags <= frags + 1'b1;
              end
              flush_hl   <= 1'b1;
              fi         <= '0;
              flush_kind <= FK_CONF;
              state      <= S_FLUSH;
            end else begin
              state <= S_CHECK;
            end
          end else if (em_go) begin
            if (hit) begin
              resume <= tp + 1'b1;
              tp     <= tp + 1'b1;
            end else begin
              if (mism < COUNT_SAT) begin
                mism <= mism + 1'b1;
              end
              rl <= '0;
            end
            if (!hit && rl != '0 && rl < m_eff) begin
              tp <= resume;
              for (int j = 0; j < QDEPTH; j++) begin
                q[j] <= nq[j];
              end
              qn <= nq_n;
            end else begin
              for (int j = 0; j < QDEPTH - 1; j++) begin
                q[j] <= q[j + 1];
              end
              qn <= qn - 1'b1;
            end
            state <= S_CHECK;
          end
        end
        S_ENDT: begin
          fi <= '0;
          flush_kind <= FK_ENDT;
          if (rl >= m_eff) begin
            matched <= 1'b1;
            rl      <= '0;
            done    <= 1'b1;
            state   <= S_CHECK;
          end else if (rl != '0 && frags != '0) begin
            if (frags < FRAG_SAT) begin
              frags <= frags + 1'b1;
            end
            matched  <= 1'b1;
            flush_hl <= 1'b1;
            state    <= S_FLUSH;
          end else begin
            flush_hl <= 1'b0;
            state    <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (fi < rl) begin
            if (em_go) begin
              fi <= fi + 1'b1;
            end
          end else begin
            case (flush_kind)
              FK_CONF: begin
                state <= S_CHECK;
              end
              FK_ENDT: begin
                rl    <= '0;
                done  <= 1'b1;
                state <= S_CHECK;
              end
              default: begin
                rl    <= '0;
                state <= S_DRAIN;
              end
            endcase
          end
        end
        S_FIN: begin
          if (fin && !done) begin
            flush_hl   <= 1'b0;
            fi         <= '0;
            flush_kind <= FK_FINAL;
            state      <= S_FLUSH;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!hold_v || move_ok) begin
            if (hold_v) begin
              out_reg <= '{out_symbol: hold.symbol, highlighted: hold.hl,
                           fragment_start: hold.fs, default: '0};
              if (fin) begin
                if (matched) begin
                  out_reg.matched        <= 1'b1;
                  out_reg.fragment_count <= frags;
                  out_reg.first_position <= (first_at > COUNT_SAT) ? COUNT_SAT
                                                                   : first_at;
                  out_reg.mismatch_count <= mism;
                end else begin
                  out_reg.matched        <= 1'b0;
                  out_reg.fragment_count <= '1;
                  out_reg.first_position <= '1;
                  out_reg.mismatch_count <= '1;
                end
              end
              out_last <= fin;
              out_v    <= 1'b1;
              hold_v   <= 1'b0;
            end
            if (fin) begin
              tp       <= '0;
              resume   <= '0;
              rl       <= '0;
              srcpos   <= '0;
              frags    <= '0;
              first_at <= '1;
              mism     <= '0;
              done     <= 1'b0;
              matched  <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The hold stage is always drained before a new item is taken.
  a_idle_hold_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !hold_v)
    else $error("hold stage not empty while idle");

  // No more results per item than the run buffer can produce.
  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    32'(res_n) <= RUN_MAX)
    else $error("too many results for one item");

  // A flush never walks past the buffered run.
  a_flush_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> (fi <= rl))
    else $error("flush index beyond run length");

  // A compare only happens while the term index is inside the term.
  a_cmp_in_term: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (tp < len_eff && !done))
    else $error("compare outside the term");

endmodule

FILE: tb/sv/tb_fuzzy_run_matcher_core.sv
// Testbench for the fuzzy run matcher core: predicted highlight beats checked against the block.
`timescale 1ns / 1ps

module tb_fuzzy_run_matcher_core;
  import frm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int FILL_SLOTS = 16;

  typedef struct {
    frm_result_t r;
    bit          eos;
  } hl_beat_t;

  // Predicts the highlight beats of each source byte and checks the block's output against them.
  class run_scoreboard;
    byte unsigned term_mem[TERM_MAX];
    byte unsigned run_buf[RUN_MAX];
    int unsigned  src_pos, term_pos, resume_pos, run_len, frags, first_at, miss;
    bit           str_done, found;
    int unsigned  min_run_reg, term_len_reg;
    hl_beat_t     res[RUN_MAX];
    int           nres;
    hl_beat_t     highlight_q[$];
    int           errors;

    function void clear_string();
      src_pos = 0; term_pos = 0; resume_pos = 0; run_len = 0; frags = 0;
      first_at = 32'hFFFF_FFFF; miss = 0; str_done = 0; found = 0;
    endfunction

    function new();
      clear_string();
      min_run_reg = 2;
      term_len_reg = 1;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [6:0] val);
      if (idx == REG_MIN_RUN) min_run_reg = val[3:0];
      else term_len_reg = val;
    endfunction

    function int unsigned run_need();
      if (min_run_reg < 1) return 1;
      if (min_run_reg > RUN_MAX) return RUN_MAX;
      return min_run_reg;
    endfunction

    function int unsigned term_need();
      if (term_len_reg < 1) return 1;
      if (term_len_reg > TERM_MAX) return TERM_MAX;
      return term_len_reg;
    endfunction

    function byte unsigned lower_case(byte unsigned c);
      return (c >= 8'h41 && c <= 8'h5A) ? byte'(c + 8'h20) : c;
    endfunction

    function void bump_miss();
      if (miss < COUNT_SAT) miss++;
    endfunction

    function void emit(byte unsigned b, bit hl, bit fs);
      if (nres >= RUN_MAX) return;
      res[nres].r = '0;
      res[nres].eos = 0;
      res[nres].r.out_symbol = b;
      res[nres].r.highlighted = hl;
      res[nres].r.fragment_start = fs;
      nres++;
      if (src_pos < SOURCE_MAX) src_pos++;
    endfunction

    function void flush_run(bit hl);
      if (hl) begin
        if (frags == 0) first_at = src_pos;
        if (frags < FRAG_SAT) frags++;
      end
      for (int i = 0; i < run_len && i < RUN_MAX; i++) emit(run_buf[i], hl, hl && i == 0);
    endfunction

    function void end_term();
      if (run_len >= run_need()) begin
        found = 1;
      end else if (run_len > 0 && frags > 0) begin
        flush_run(1);
        found = 1;
      end else begin
        flush_run(0);
      end
      run_len = 0;
      str_done = 1;
    endfunction

    function void note_input(logic cmd, byte unsigned sym, logic [5:0] slot, logic fin);
      byte unsigned q[RUN_MAX+1];
      byte unsigned nq[RUN_MAX+1];
      byte unsigned b;
      int qn, qi, nn, m;
      if (cmd == CMD_TERM) begin
        term_mem[slot] = sym;
        return;
      end
      nres = 0;
      m = run_need();
      if (run_len > m) run_len = m;
      q[0] = sym; qn = 1; qi = 0;
      while (qi < qn) begin
        b = q[qi];
        qi++;
        if (!str_done && term_pos >= term_need()) end_term();
        if (str_done) begin
          emit(b, 0, 0);
          if (found) bump_miss();
          continue;
        end
        if (lower_case(term_mem[term_pos]) == lower_case(b)) begin
          if (run_len < m) begin
            run_buf[run_len] = b;
            run_len++;
            if (run_len == m) begin
              resume_pos = term_pos + 1;
              flush_run(1);
            end
          end else begin
            resume_pos = term_pos + 1;
            emit(b, 1, 0);
          end
          term_pos++;
          if (term_pos >= term_need()) end_term();
        end else if (run_len > 0 && run_len < m) begin
          // A short run broke: its first byte goes out plain, the rest is compared again.
          term_pos = resume_pos;
          emit(run_buf[0], 0, 0);
          bump_miss();
          nn = 0;
          for (int i = 1; i < run_len; i++) begin
            nq[nn] = run_buf[i];
            nn++;
          end
          for (int i = qi - 1; i < qn && nn < RUN_MAX + 1; i++) begin
            nq[nn] = q[i];
            nn++;
          end
          for (int i = 0; i < nn; i++) q[i] = nq[i];
          qn = nn; qi = 0; run_len = 0;
        end else begin
          emit(b, 0, 0);
          bump_miss();
          run_len = 0;
        end
      end
      if (fin) begin
        if (!str_done) begin
          flush_run(0);
          run_len = 0;
        end
        if (nres > 0) begin
          res[nres-1].eos = 1;
          if (found) begin
            res[nres-1].r.matched = 1;
            res[nres-1].r.fragment_count = FC_W'(frags);
            res[nres-1].r.first_position = (first_at > COUNT_SAT) ? COUNT_SAT
                                                                  : SP_W'(first_at);
            res[nres-1].r.mismatch_count = SP_W'(miss);
          end else begin
            res[nres-1].r.matched = 0;
            res[nres-1].r.fragment_count = '1;
            res[nres-1].r.first_position = '1;
            res[nres-1].r.mismatch_count = '1;
          end
        end
        clear_string();
      end
      for (int i = 0; i < nres; i++) highlight_q.push_back(res[i]);
    endfunction

    function void check_beat(logic [47:0] data, logic last);
      frm_result_t got;
      hl_beat_t    want;
      got = data[40:0];
      if (highlight_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: data %h last %b", data, last);
        return;
      end
      want = highlight_q.pop_front();
      if (got.out_symbol !== want.r.out_symbol || got.highlighted !== want.r.highlighted ||
          got.fragment_start !== want.r.fragment_start || got.matched !== want.r.matched ||
          got.fragment_count !== want.r.fragment_count ||
          got.first_position !== want.r.first_position ||
          got.mismatch_count !== want.r.mismatch_count || last !== want.eos) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: sym %h/%h hl %b/%b fs %b/%b eos %b/%b m %b/%b fc %0d/%0d fp %0d/%0d mc %0d/%0d (exp/got)",
                   want.r.out_symbol, got.out_symbol, want.r.highlighted, got.highlighted,
                   want.r.fragment_start, got.fragment_start, want.eos, last,
                   want.r.matched, got.matched, want.r.fragment_count, got.fragment_count,
                   want.r.first_position, got.first_position,
                   want.r.mismatch_count, got.mismatch_count);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [6:0]  cfg_data = '0;

  run_scoreboard sb = new();
  bit            calm = 0;
  int            cycles = 0;
  int            items = 0;
  byte unsigned  term_copy[TERM_MAX];

  fuzzy_run_matcher_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_fuzzy_run_matcher_core failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata[7:0], s_tdata[13:8], s_tlast);
      if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) m_tready <= calm || ($urandom_range(99) >= 36);

  task automatic send(logic cmd, byte unsigned sym, logic [5:0] slot, logic fin);
    if (!calm && $urandom_range(99) < 36) begin
      s_tvalid <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, slot, sym};
    s_tlast <= fin;
    if (cmd == CMD_TERM) term_copy[slot] = sym;
    @(posedge clk);
    while (!(s_tvalid && s_tready)) @(posedge clk);
    items++;
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send(CMD_SOURCE, s[i], 6'($urandom), i == s.len() - 1);
  endtask

  // Drain all expected beats and let the block finish any byte still in work.
  task automatic settle();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.highlight_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic byte unsigned flip_case(byte unsigned c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) return c ^ 8'h20;
    return c;
  endfunction

  initial begin
    int len, pos, mr, tl;
    byte unsigned c;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Strings are at most ten bytes long, so filling the first slots keeps every
    // compare on a written term byte.
    for (int i = 0; i < FILL_SLOTS; i++) begin
      c = 8'(8'h61 + $urandom_range(3));
      if ($urandom_range(1)) c = c ^ 8'h20;
      case (i)
        0: c = "H";
        1: c = "e";
        2: c = "L";
        3: c = "l";
        4: c = "o";
        default: ;
      endcase
      send(CMD_TERM, c, 6'(i), 1'b0);
    end
    settle();
    write_cfg(REG_MIN_RUN, 7'd2);
    write_cfg(REG_TERM_LEN, 7'd5);
    send_str("hello");
    send_str("hELxlo");
    send_str("xHELLOzz");
    send_str("h");
    send(CMD_TERM, 8'hFF, 6'd63, 1'b1);
    send(CMD_SOURCE, 8'h00, 6'd0, 1'b0);
    send(CMD_SOURCE, 8'hFF, 6'd63, 1'b1);
    settle();
    write_cfg(REG_MIN_RUN, 7'd0);
    write_cfg(REG_TERM_LEN, 7'd127);
    send_str("Hel");
    settle();
    write_cfg(REG_MIN_RUN, 7'd15);
    write_cfg(REG_TERM_LEN, 7'd0);
    send_str("hH");
    settle();
    write_cfg(REG_MIN_RUN, 7'd3);
    write_cfg(REG_TERM_LEN, 7'd5);
    send_str("HelLo");

    while (items < 110) begin
      calm = (items > 70 && items < 95);
      if ($urandom_range(3) == 0) begin
        settle();
        mr = $urandom_range(15);
        case ($urandom_range(5))
          0: tl = 64;
          1: tl = $urandom_range(127);
          default: tl = $urandom_range(8, 1);
        endcase
        write_cfg(REG_MIN_RUN, 7'(mr));
        write_cfg(REG_TERM_LEN, 7'(tl));
      end
      if ($urandom_range(5) == 0) send(CMD_TERM, 8'($urandom), 6'($urandom), 1'($urandom));
      len = $urandom_range(10, 1);
      pos = 0;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) begin
          c = 8'($urandom);
        end else begin
          if ($urandom_range(7) == 0) pos++;
          c = term_copy[pos % TERM_MAX];
          if ($urandom_range(1)) c = flip_case(c);
          pos++;
        end
        send(CMD_SOURCE, c, 6'($urandom), i == len - 1);
      end
    end
    calm = 0;
    settle();
    if (sb.errors == 0 && sb.highlight_q.size() == 0) begin
      $display("tb_fuzzy_run_matcher_core passed");
    end else begin
      $display("tb_fuzzy_run_matcher_core failed");
    end
    $finish;
  end

endmodule
